// File: rtl/usd_pkg.sv
// usd_pkg: types, status codes and decode helpers for the UTF-8 stream decoder.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package usd_pkg;

	// Result status codes as they appear on the status port
	localparam logic [1:0] ST_VALID = 2'd0;
	localparam logic [1:0] ST_UNDEF = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	// Top two bits of a continuation byte
	localparam logic [1:0] CONT_TAG = 2'b10;

	// Lead bytes 0xFE and 0xFF share these seven upper bits
	localparam logic [6:0] BAD_LEAD_TAG = 7'h7F;

	localparam logic [30:0] UNDEF_CODE_RESET = 31'd65533;

	// One queue entry: the results caused by one accepted byte
	typedef struct packed {
		logic [1:0]  r0_status;
		logic [30:0] r0_code;
		logic        two;        // a second result follows
		logic [1:0]  r1_status;
		logic [7:0]  r1_code;    // second result is at most a 7-bit character
	} usd_entry_t;

	// Classification of a byte taken as a lead byte
	typedef struct packed {
		logic       has_res;
		logic [1:0] status;
		logic [7:0] code;
		logic       load;        // starts a multi-byte sequence
		logic [2:0] len;
		logic [4:0] payload;
	} usd_lead_t;

	function automatic usd_lead_t lead_decode(input logic [7:0] b, input logic last);
		usd_lead_t r;
		logic      starts;
		r       = '0;
		starts  = 1'b0;
		if (b == 8'd0) begin
			r.has_res = 1'b1;
			r.status  = ST_UNDEF;
		end else if (!b[7]) begin
			r.has_res = 1'b1;
			r.status  = ST_VALID;
			r.code    = b;
		end else if (!b[6]) begin
			r.has_res = 1'b1;
			r.status  = ST_UNDEF;
		end else if (b[7:1] == BAD_LEAD_TAG) begin
			r.has_res = 1'b1;
			r.status  = ST_UNDEF;
		end else begin
			starts = 1'b1;
			if (!b[5]) begin
				r.len     = 3'd2;
				r.payload = b[4:0];
			end else if (!b[4]) begin
				r.len     = 3'd3;
				r.payload = {1'b0, b[3:0]};
			end else if (!b[3]) begin
				r.len     = 3'd4;
				r.payload = {2'b00, b[2:0]};
			end else if (!b[2]) begin
				r.len     = 3'd5;
				r.payload = {3'b000, b[1:0]};
			end else begin
				r.len     = 3'd6;
				r.payload = {4'b0000, b[0]};
			end
		end
		if (starts && last) begin
			// sequence begins on the final byte: truncated, nothing kept
			r.has_res = 1'b1;
			r.status  = ST_TRUNC;
			r.code    = 8'd0;
			r.len     = 3'd0;
			r.payload = 5'd0;
		end else begin
			r.load = starts;
		end
		return r;
	endfunction

	// Shortest encoding length of a code point
	function automatic logic [2:0] enc_len(input logic [30:0] c);
		logic [2:0] n;
		if (c <= 31'h7F)           n = 3'd1;
		else if (c <= 31'h7FF)     n = 3'd2;
		else if (c <= 31'hFFFF)    n = 3'd3;
		else if (c <= 31'h1FFFFF)  n = 3'd4;
		else if (c <= 31'h3FFFFFF) n = 3'd5;
		else                       n = 3'd6;
		return n;
	endfunction

endpackage

`default_nettype wire

// File: rtl/usd_front.sv
// usd_front: accepts input bytes, tracks the pending sequence and builds one
// queue entry per byte that causes results. Depends on usd_pkg.
`default_nettype none

module usd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        byte_value,
	input  wire logic              last_byte,
	input  wire logic              q_full,
	output logic                   push,
	output usd_pkg::usd_entry_t    entry
);

	logic [30:0] acc_q;
	logic [2:0]  rem_q;
	logic [2:0]  len_q;

	logic [30:0] acc_n;
	logic [2:0]  rem_n;
	logic [2:0]  len_n;
	logic [30:0] acc_cat;
	logic [2:0]  rem_dec;
	logic        push_c;
	logic        fire;
	usd_pkg::usd_lead_t ld;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;
	assign push     = fire && push_c;

	always_comb begin
		ld      = usd_pkg::lead_decode(byte_value, last_byte);
		acc_cat = {acc_q[24:0], byte_value[5:0]};
		rem_dec = rem_q - 3'd1;
		entry   = '0;
		push_c  = 1'b0;
		acc_n   = acc_q;
		rem_n   = rem_q;
		len_n   = len_q;
		if (rem_q == 3'd0) begin
			push_c          = ld.has_res;
			entry.r0_status = ld.status;
			entry.r0_code   = {23'd0, ld.code};
			acc_n = ld.load ? {26'd0, ld.payload} : 31'd0;
			len_n = ld.load ? ld.len : 3'd0;
			rem_n = ld.load ? ld.len - 3'd1 : 3'd0;
		end else if (byte_value == 8'd0) begin
			// null inside a sequence is swallowed
			push_c          = 1'b1;
			entry.r0_status = usd_pkg::ST_UNDEF;
			acc_n = 31'd0;
			len_n = 3'd0;
			rem_n = 3'd0;
		end else if (byte_value[7:6] != usd_pkg::CONT_TAG) begin
			// abort the sequence, then reuse the byte as a lead byte
			push_c          = 1'b1;
			entry.r0_status = usd_pkg::ST_UNDEF;
			entry.two       = ld.has_res;
			entry.r1_status = ld.status;
			entry.r1_code   = ld.code;
			acc_n = ld.load ? {26'd0, ld.payload} : 31'd0;
			len_n = ld.load ? ld.len : 3'd0;
			rem_n = ld.load ? ld.len - 3'd1 : 3'd0;
		end else begin
			acc_n = acc_cat;
			rem_n = rem_dec;
			if (rem_dec == 3'd0) begin
				push_c          = 1'b1;
				entry.r0_status = (usd_pkg::enc_len(acc_cat) == len_q) ?
					usd_pkg::ST_VALID : usd_pkg::ST_UNDEF;
				entry.r0_code   = acc_cat;
				acc_n = 31'd0;
				len_n = 3'd0;
			end else if (last_byte) begin
				push_c          = 1'b1;
				entry.r0_status = usd_pkg::ST_TRUNC;
				acc_n = 31'd0;
				len_n = 3'd0;
				rem_n = 3'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 31'd0;
			rem_q <= 3'd0;
			len_q <= 3'd0;
		end else if (fire) begin
			acc_q <= acc_n;
			rem_q <= rem_n;
			len_q <= len_n;
		end
	end

	// idle means nothing gathered; pending means fewer bytes left than the length
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == 3'd0) |-> (len_q == 3'd0 && acc_q == 31'd0))
		else $error("front idle with stale sequence state");

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != 3'd0) |-> (rem_q < len_q))
		else $error("front remaining count not below sequence length");

endmodule

`default_nettype wire

// File: rtl/usd_fifo.sv
// usd_fifo: short register queue of result entries between front and back.
// Depends on usd_pkg for the entry type.
`default_nettype none

module usd_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire usd_pkg::usd_entry_t  wr_entry,
	output logic                      full,
	output logic                      not_empty,
	input  wire logic                 pop,
	output usd_pkg::usd_entry_t       rd_entry
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	usd_pkg::usd_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");

endmodule

`default_nettype wire

// File: rtl/usd_back.sv
// usd_back: drains queue entries into the output register, one result per
// cycle unless out_ready stalls it, and substitutes the undefined code. Depends on usd_pkg.
`default_nettype none

module usd_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [30:0]          undefined_code,
	input  wire logic                 q_valid,
	input  wire usd_pkg::usd_entry_t  q_entry,
	output logic                      q_pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [30:0]               code_point,
	output logic [1:0]                status,
	output logic                      run_end
);

	logic        out_valid_q;
	logic [30:0] code_q;
	logic [1:0]  status_q;
	logic        run_end_q;
	logic        pend_q;
	logic [1:0]  pend_status_q;
	logic [7:0]  pend_code_q;
	logic        out_free;

	assign out_free   = !out_valid_q || out_ready;
	assign q_pop      = out_free && !pend_q && q_valid;
	assign out_valid  = out_valid_q;
	assign code_point = code_q;
	assign status     = status_q;
	assign run_end    = run_end_q;

	// payload: second result of a two-result entry goes out first if waiting
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				status_q  <= pend_status_q;
				code_q    <= (pend_status_q == usd_pkg::ST_UNDEF) ?
					undefined_code : {23'd0, pend_code_q};
				run_end_q <= 1'b1;
			end else if (q_valid) begin
				status_q  <= q_entry.r0_status;
				code_q    <= (q_entry.r0_status == usd_pkg::ST_UNDEF) ?
					undefined_code : q_entry.r0_code;
				run_end_q <= !q_entry.two;
			end
		end
		if (q_pop) begin
			pend_status_q <= q_entry.r1_status;
			pend_code_q   <= q_entry.r1_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pend_q || q_valid;
			pend_q      <= q_pop && q_entry.two;
		end
	end

	a_pend_shown: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (out_valid_q && !run_end_q))
		else $error("second result pending without a first one on the output");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q == usd_pkg::ST_VALID || status_q == usd_pkg::ST_UNDEF
			|| status_q == usd_pkg::ST_TRUNC))
		else $error("output status outside the defined codes");

endmodule

`default_nettype wire

// File: rtl/utf8_stream_decoder_top.sv
// utf8_stream_decoder_top: byte-stream decoder for six-byte UTF-8.
// Instantiates usd_front, usd_fifo and usd_back; depends on usd_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready): one byte per transaction, with
//    last_byte marking the final byte of a string.
//  - Output channel (out_valid/out_ready): one result per transaction:
//    code_point, status (valid / undefined / truncated) and run_end, which
//    is set on the last result caused by a given input byte.
//  - cfg_we/cfg_wdata write the undefined code; write only while idle.
//  - Throughput: one byte per cycle. A byte that aborts a pending sequence
//    and then decodes on its own yields two results, which take two output
//    transactions; the entry queue absorbs that and the input stalls only when
//    it fills.
//  - Result path: a result passes from its byte's transaction through a
//    queue entry and then the output register.
//  - Reset: arst_n clears the sequence state, the queue and the output
//    valid, and sets the undefined code to U+FFFD.
//  - Output stall: the output register holds while out_ready is low; the
//    queue keeps taking bytes until it is full, then in_ready drops.
`default_nettype none

module utf8_stream_decoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [30:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  byte_value,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [30:0]      code_point,
	output logic [1:0]       status,
	output logic             run_end
);

	logic [30:0]         undef_code_q;
	logic                q_full;
	logic                q_not_empty;
	logic                q_push;
	logic                q_pop;
	usd_pkg::usd_entry_t wr_entry;
	usd_pkg::usd_entry_t rd_entry;

	// undefined code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			undef_code_q <= usd_pkg::UNDEF_CODE_RESET;
		end else if (cfg_we) begin
			undef_code_q <= cfg_wdata;
		end
	end

	// front: classify bytes and track the pending sequence
	usd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.push       (q_push),
		.entry      (wr_entry)
	);

	// queue decouples the front from output stalls
	usd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (wr_entry),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.rd_entry  (rd_entry)
	);

	// back: one result per output transaction
	usd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.undefined_code (undef_code_q),
		.q_valid        (q_not_empty),
		.q_entry        (rd_entry),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.code_point     (code_point),
		.status         (status),
		.run_end        (run_end)
	);

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_decoder_top: six-byte UTF-8 byte stream to code points.
// Holds its own decoder predictor and scoreboard; depends on usd_pkg and the RTL only.

package usd_tb_pkg;

	typedef struct packed {
		logic [30:0] code;
		logic [1:0]  status;
		logic        run_end;
	} usd_result_t;

	class usd_scoreboard;
		usd_result_t expected_q[$];
		usd_result_t batch[$];
		logic [30:0] undef_code;
		logic [30:0] acc;
		logic [2:0]  remaining;
		logic [2:0]  seq_len;
		int          n_checked;
		int          n_undef;
		int          n_trunc;
		int          n_errors;

		function new();
			undef_code = usd_pkg::UNDEF_CODE_RESET;
			acc        = '0;
			remaining  = '0;
			seq_len    = '0;
			n_checked  = 0;
			n_undef    = 0;
			n_trunc    = 0;
			n_errors   = 0;
		endfunction

		function void set_undef_code(input logic [30:0] v);
			undef_code = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void add(input logic [30:0] code, input logic [1:0] st);
			usd_result_t r;
			r.code    = code;
			r.status  = st;
			r.run_end = 1'b0;
			batch.push_back(r);
		endfunction

		function void drop_sequence();
			acc       = '0;
			remaining = '0;
			seq_len   = '0;
		endfunction

		// byte taken as the start of a character while no sequence is open
		function void decode_lead(input logic [7:0] b, input logic l);
			logic [2:0] len;
			logic [7:0] payload;
			len = 3'd0;
			if (b == 8'd0) begin
				add(undef_code, usd_pkg::ST_UNDEF);
			end else if (!b[7]) begin
				add({23'd0, b}, usd_pkg::ST_VALID);
			end else if (b[7:6] == usd_pkg::CONT_TAG || b >= 8'hFE) begin
				add(undef_code, usd_pkg::ST_UNDEF);
			end else begin
				// length is the position of the first zero below the top bit
				for (int k = 2; k <= 6; k++) begin
					if (len == 3'd0 && !b[7-k])
						len = 3'(k);
				end
				payload = b & (8'hFF >> (len + 3'd1));
				if (l) begin
					drop_sequence();
					add('0, usd_pkg::ST_TRUNC);
				end else begin
					acc       = {23'd0, payload};
					seq_len   = len;
					remaining = len - 3'd1;
				end
			end
		endfunction

		// one accepted byte: advance the decoder state, queue what it yields
		function void note_byte(input logic [7:0] b, input logic l);
			logic [2:0] shortest;
			batch.delete();
			if (remaining == 3'd0) begin
				decode_lead(b, l);
			end else if (b == 8'd0) begin
				drop_sequence();
				add(undef_code, usd_pkg::ST_UNDEF);
			end else if (b[7:6] != usd_pkg::CONT_TAG) begin
				// the sequence dies, then the same byte starts over
				drop_sequence();
				add(undef_code, usd_pkg::ST_UNDEF);
				decode_lead(b, l);
			end else begin
				acc       = {acc[24:0], b[5:0]};
				remaining = remaining - 3'd1;
				if (remaining == 3'd0) begin
					shortest = (acc <= 31'h7F)      ? 3'd1 :
					           (acc <= 31'h7FF)     ? 3'd2 :
					           (acc <= 31'hFFFF)    ? 3'd3 :
					           (acc <= 31'h1FFFFF)  ? 3'd4 :
					           (acc <= 31'h3FFFFFF) ? 3'd5 : 3'd6;
					if (shortest == seq_len)
						add(acc, usd_pkg::ST_VALID);
					else
						add(undef_code, usd_pkg::ST_UNDEF);
					acc     = '0;
					seq_len = '0;
				end else if (l) begin
					drop_sequence();
					add('0, usd_pkg::ST_TRUNC);
				end
			end
			if (batch.size() > 0)
				batch[batch.size()-1].run_end = 1'b1;
			foreach (batch[i])
				expected_q.push_back(batch[i]);
		endfunction

		function void flag(input string what);
			n_errors++;
			if (n_errors <= 10)
				$display("[%0t] MISMATCH %s", $realtime, what);
		endfunction

		function void check(input logic [30:0] code, input logic [1:0] st, input logic re);
			usd_result_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("unexpected result code %h status %0d run_end %0b",
					code, st, re));
				return;
			end
			want = expected_q.pop_front();
			n_checked++;
			if (want.status == usd_pkg::ST_UNDEF) n_undef++;
			if (want.status == usd_pkg::ST_TRUNC) n_trunc++;
			if (code !== want.code || st !== want.status || re !== want.run_end)
				flag($sformatf("exp code %h status %0d run_end %0b, got %h %0d %0b",
					want.code, want.status, want.run_end, code, st, re));
		endfunction
	endclass

endpackage

module testbench;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [30:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_value;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [30:0] code_point;
	logic [1:0]  status;
	logic        run_end;

	usd_tb_pkg::usd_scoreboard sb;
	int            n_sent;
	int            n_cfg;
	bit            quiet;     // phase with no idle cycles on either side
	int            stall_left;

	utf8_stream_decoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_point (code_point),
		.status     (status),
		.run_end    (run_end)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_idle();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	// Upper bound of the code points that need exactly len bytes
	function automatic logic [31:0] len_top(input int len);
		case (len)
			1:       return 32'h7F;
			2:       return 32'h7FF;
			3:       return 32'hFFFF;
			4:       return 32'h1FFFFF;
			5:       return 32'h3FFFFFF;
			default: return 32'h7FFFFFFF;
		endcase
	endfunction

	// Offer one byte after a random gap and hold it until the transaction.
	// Signals are sampled right at the edge, so in_ready here is the pre-edge value.
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = pick_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		byte_value <= b;
		last_byte  <= l;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b, l);
		n_sent++;
	endtask

	// Let every result drain, give the pipeline time to retire bytes that
	// yield nothing, then write the undefined code.
	task automatic write_undef_code(input logic [30:0] v);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_undef_code(v);
		n_cfg++;
	endtask

	// Random strings: mostly well-formed characters of every length, with
	// overlong forms, damaged and cut-off sequences, and raw noise mixed in.
	task automatic random_phase(input int count);
		logic [7:0]  str[$];
		logic [7:0]  seq[$];
		logic [7:0]  tag;
		logic [31:0] cp;
		logic [31:0] lo;
		int          stop_at;
		int          n_chars;
		int          len;
		int          mode;
		int          pos;
		bit          cut;
		stop_at = n_sent + count;
		while (n_sent < stop_at) begin
			str.delete();
			cut     = 1'b0;
			n_chars = $urandom_range(8, 1);
			for (int c = 0; c < n_chars && !cut; c++) begin
				mode = $urandom_range(99);
				if (mode < 8) begin
					str.push_back(8'($urandom_range(255)));
				end else begin
					len = $urandom_range(6, 1);
					lo  = (len == 1) ? 32'd1 : len_top(len - 1) + 32'd1;
					case ($urandom_range(7))
						0:       cp = lo;
						1:       cp = len_top(len);
						default: cp = $urandom_range(len_top(len), lo);
					endcase
					// overlong: a value short enough for fewer bytes
					if (mode < 16 && len > 1)
						cp = $urandom_range(len_top(len - 1), 0);
					seq.delete();
					if (len == 1) begin
						seq.push_back(cp[7:0]);
					end else begin
						tag = 8'hFF << (8 - len);
						seq.push_back(tag | 8'(cp >> (6 * (len - 1))));
						for (int k = len - 2; k >= 0; k--)
							seq.push_back(8'h80 | (8'(cp >> (6 * k)) & 8'h3F));
					end
					if (mode >= 16 && mode < 24 && len > 1) begin
						// damage one continuation byte
						pos = $urandom_range(len - 1, 1);
						case ($urandom_range(3))
							0:       seq[pos] = 8'h00;
							1:       seq[pos] = 8'($urandom_range(8'h7F, 1));
							2:       seq[pos] = 8'($urandom_range(8'hFF, 8'hC0));
							default: seq[pos] = 8'($urandom_range(255));
						endcase
					end else if (mode >= 24 && mode < 30 && len > 1) begin
						// string ends inside the sequence
						pos = $urandom_range(len - 1, 1);
						while (seq.size() > pos)
							void'(seq.pop_back());
						cut = 1'b1;
					end
					foreach (seq[i])
						str.push_back(seq[i]);
				end
			end
			foreach (str[i])
				send_byte(str[i], i == str.size() - 1);
		end
	endtask

	// Result side: check every transaction, stall at random.
	initial begin
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check(code_point, status, run_end);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_idle();
			end
		end
	end

	// Main sequence
	initial begin
		sb         = new();
		n_sent     = 0;
		n_cfg      = 0;
		quiet      = 1'b0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		byte_value = '0;
		last_byte  = 1'b0;
		out_ready  = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single-byte cases, including last_byte on a plain char
		send_byte(8'h00, 1'b0);            // zero lead byte
		send_byte(8'h41, 1'b1);            // last_byte with nothing pending
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);            // stray continuation
		send_byte(8'hFE, 1'b0);
		send_byte(8'hFF, 1'b0);
		// two-byte char, then an overlong two-byte form
		send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
		send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
		// largest six-byte code point
		send_byte(8'hFD, 1'b0);
		repeat (5) send_byte(8'hBF, 1'b0);
		// zero byte inside a sequence is swallowed
		send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'h00, 1'b0);
		// ASCII inside a sequence: two results from one byte
		send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
		// new lead inside a sequence: abort, then the new char completes
		send_byte(8'hE2, 1'b0); send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
		// string ends mid-sequence, and on a lone lead byte
		send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b1);
		send_byte(8'hC3, 1'b1);

		write_undef_code(31'd0);
		random_phase(200);
		write_undef_code(31'h7FFFFFFF);
		quiet = 1'b1;
		random_phase(200);
		quiet = 1'b0;
		write_undef_code(31'($urandom));
		random_phase(200);
		write_undef_code(usd_pkg::UNDEF_CODE_RESET);
		random_phase(200);

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.n_errors++;
			$display("%0d expected results never arrived", sb.pending());
		end

		$display("%0d bytes decoded into %0d results (%0d undefined, %0d truncated)",
			n_sent, sb.n_checked, sb.n_undef, sb.n_trunc);
		$display("%0d undefined-code writes, %0d mismatches", n_cfg, sb.n_errors);
		if (sb.n_errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("timeout after %0d bytes", n_sent);
		$display("testbench failed");
		$finish;
	end

endmodule
